// ===== rtl/smm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Systolic matrix multiply-accumulate package
// Item types, widths, command codes and controller states shared by the block.
// ----------------------------------------------------------------------------
package smm_pkg;

	localparam int DATA_W = 16;
	localparam int PROD_W = 32;
	localparam int ACC_W  = 48;
	localparam int CFG_W  = 7;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_LOAD_C = 2'd2,
		CMD_RUN    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FEED  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic [1:0]               cmd;
		logic [5:0]               row;
		logic [5:0]               column;
		logic signed [DATA_W-1:0] data_value;
		logic signed [ACC_W-1:0]  init_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]              result_row;
		logic [2:0]              result_col;
		logic signed [ACC_W-1:0] result_value;
		logic                    last;
	} out_item_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic load;
		logic rotate;
	} cell_ctrl_t;

endpackage

// ===== rtl/smm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/smm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Systolic processing cell
// Holds one accumulator, multiplies the passing operands and forwards them.
// ----------------------------------------------------------------------------
module smm_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smm_pkg::cell_ctrl_t               ctrl,
	input  logic signed [smm_pkg::DATA_W-1:0] a_in,
	input  logic signed [smm_pkg::DATA_W-1:0] b_in,
	input  logic signed [smm_pkg::ACC_W-1:0]  load_value,
	input  logic signed [smm_pkg::ACC_W-1:0]  rot_in,
	output logic signed [smm_pkg::DATA_W-1:0] a_out,
	output logic signed [smm_pkg::DATA_W-1:0] b_out,
	output logic signed [smm_pkg::ACC_W-1:0]  acc
);
	import smm_pkg::*;

	logic signed [DATA_W-1:0] a_q, b_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod;

	assign prod = a_in * b_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			acc_q <= '0;
		end else begin
			if (ctrl.clear) begin
				a_q <= '0;
				b_q <= '0;
			end else if (ctrl.step) begin
				a_q <= a_in;
				b_q <= b_in;
			end
			if (ctrl.load) begin
				acc_q <= load_value;
			end else if (ctrl.rotate) begin
				acc_q <= rot_in;
			end else if (ctrl.step) begin
				acc_q <= acc_q + ACC_W'(prod);
			end
		end
	end

	assign a_out = a_q;
	assign b_out = b_q;
	assign acc   = acc_q;
endmodule

// ===== rtl/systolic_matmul_accumulate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Systolic matrix multiply-accumulate
// Output-stationary grid of cells computing C = C + A * B.
// ----------------------------------------------------------------------------
// Input items carry a command. Loads of A, B or an initial C entry are taken
// back to back and give no result; loads with an index outside the grid are
// dropped. A run item feeds the skewed operands from one A memory per row and
// one B memory per column, one beat a cycle, until every operand within the
// reduction length has passed through the whole grid.
// The accumulators then rotate through a ring in row-major order, and cell
// (0,0) drives the output: ROWS * COLS result items, one per cycle unless
// the receiver stalls. A stall freezes the ring, so the item on the output
// holds. After the full rotation every accumulator is back in its own cell
// and a later run adds on top of it. One item is worked on at a time; the
// input stalls from a run until its last result is taken.
// Reset clears the accumulators, the operand pipes and reduction_length; the
// operand memories are not cleared.
// reduction_length is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
module systolic_matmul_accumulate #(
	parameter int ROWS      = 8,
	parameter int COLS      = 8,
	parameter int DEPTH_MAX = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  smm_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output smm_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import smm_pkg::*;

	localparam int N  = ROWS * COLS;
	localparam int AW = DEPTH_MAX > 1 ? $clog2(DEPTH_MAX) : 1;
	localparam int LW = $clog2(DEPTH_MAX + 1);
	localparam int TW = $clog2(DEPTH_MAX + ROWS + COLS);
	localparam int RW = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int CW = COLS > 1 ? $clog2(COLS) : 1;

	state_t          state_q;
	logic [LW-1:0]   len_q;
	logic [TW-1:0]   t_q;
	logic [TW-1:0]   beats;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic            step_s1;
	logic            in_acc, out_acc, run_go, issue, last_out;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = 32'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			len_q <= (pwdata[CFG_W-1:0] > CFG_W'(DEPTH_MAX)) ? LW'(DEPTH_MAX)
				: pwdata[LW-1:0];
		end
	end

	// Control
	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign run_go    = in_acc && in_item.cmd == CMD_RUN;
	assign beats     = TW'(len_q) + TW'(ROWS + COLS - 2);
	assign issue     = state_q == ST_FEED && t_q < beats;
	assign out_valid = state_q == ST_DRAIN;
	assign out_acc   = out_valid && !out_stall;
	assign last_out  = row_q == RW'(ROWS - 1) && col_q == CW'(COLS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			t_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (run_go) begin
						state_q <= ST_FEED;
						t_q     <= '0;
					end
				end
				ST_FEED: begin
					// The last beat's cells update at the edge that leaves this state.
					if (issue) begin
						t_q <= t_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
						row_q   <= '0;
						col_q   <= '0;
					end
				end
				ST_DRAIN: begin
					if (out_acc) begin
						if (last_out) begin
							state_q <= ST_IDLE;
						end else if (col_q == CW'(COLS - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operand feed and cell grid
	logic signed [DATA_W-1:0] a_h [ROWS][COLS+1];
	logic signed [DATA_W-1:0] b_v [ROWS+1][COLS];
	logic signed [ACC_W-1:0]  acc_w [N];

	for (genvar i = 0; i < ROWS; i++) begin : g_arow
		logic [DATA_W-1:0] rd;
		logic [TW-1:0]     k;
		logic              ok_s1;
		logic              we;

		assign k  = t_q - TW'(i);
		assign we = in_acc && in_item.cmd == CMD_LOAD_A && int'(in_item.row) == i
			&& int'(in_item.column) < DEPTH_MAX;

		smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH_MAX)) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(in_item.column[AW-1:0]),
			.wdata(in_item.data_value),
			.raddr(k[AW-1:0]),
			.rdata(rd)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ok_s1 <= 1'b0;
			end else begin
				ok_s1 <= issue && t_q >= TW'(i) && k < TW'(len_q);
			end
		end

		assign a_h[i][0] = ok_s1 ? $signed(rd) : '0;
	end

	for (genvar j = 0; j < COLS; j++) begin : g_bcol
		logic [DATA_W-1:0] rd;
		logic [TW-1:0]     k;
		logic              ok_s1;
		logic              we;

		assign k  = t_q - TW'(j);
		assign we = in_acc && in_item.cmd == CMD_LOAD_B && int'(in_item.column) == j
			&& int'(in_item.row) < DEPTH_MAX;

		smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH_MAX)) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(in_item.row[AW-1:0]),
			.wdata(in_item.data_value),
			.raddr(k[AW-1:0]),
			.rdata(rd)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ok_s1 <= 1'b0;
			end else begin
				ok_s1 <= issue && t_q >= TW'(j) && k < TW'(len_q);
			end
		end

		assign b_v[0][j] = ok_s1 ? $signed(rd) : '0;
	end

	for (genvar i = 0; i < ROWS; i++) begin : g_row
		for (genvar j = 0; j < COLS; j++) begin : g_col
			cell_ctrl_t ctrl;

			assign ctrl.step   = step_s1;
			assign ctrl.clear  = run_go;
			assign ctrl.load   = in_acc && in_item.cmd == CMD_LOAD_C
				&& int'(in_item.row) == i && int'(in_item.column) == j;
			assign ctrl.rotate = out_acc;

			smm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.a_in      (a_h[i][j]),
				.b_in      (b_v[i][j]),
				.load_value(in_item.init_value),
				.rot_in    (acc_w[(i * COLS + j + 1) % N]),
				.a_out     (a_h[i][j+1]),
				.b_out     (b_v[i+1][j]),
				.acc       (acc_w[i * COLS + j])
			);
		end
	end

	assign out_item.result_row   = 3'(row_q);
	assign out_item.result_col   = 3'(col_q);
	assign out_item.result_value = acc_w[0];
	assign out_item.last         = last_out;

`ifndef SYNTHESIS
	a_feed_only: assert property (@(posedge clk) disable iff (!arst_n)
		step_s1 |-> $past(state_q) == ST_FEED)
		else $error("cell step outside the feed phase");

	a_drain_from_feed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FEED && row_q == '0 && col_q == '0)
		else $error("drain started without a run or at a nonzero entry");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_q) && $stable(col_q))
		else $error("result position moved while stalled");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_out |=> state_q == ST_IDLE)
		else $error("block did not return to idle after the last item");
`endif
endmodule

// ===== verif/systolic_matmul_accumulate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Systolic matrix multiply-accumulate testbench
// Loads A, B and initial C entries, starts runs and compares every emitted
// C entry with an in-bench model of the grid, under random gaps and stalls.
// ----------------------------------------------------------------------------
module systolic_matmul_accumulate_tb;
	import smm_pkg::*;

	localparam int ROWS = 8;
	localparam int COLS = 8;
	localparam int DEPTH = 64;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	out_item_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	systolic_matmul_accumulate dut (.*);

	always #6 clk = ~clk;

	// Shadow of the block's state.
	logic [15:0] a_mem [ROWS][DEPTH];
	logic [15:0] b_mem [DEPTH][COLS];
	bit a_known [ROWS][DEPTH];
	bit b_known [DEPTH][COLS];
	logic [47:0] c_acc [ROWS][COLS];
	int unsigned red_len;
	out_item_t pending_entries [$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit feeding_done = 1'b0;

	task automatic report(input string what, input out_item_t got, input out_item_t want);
		$display("mismatch %s: got r%0d c%0d v%h l%0d, want r%0d c%0d v%h l%0d", what,
			got.result_row, got.result_col, got.result_value, got.last,
			want.result_row, want.result_col, want.result_value, want.last);
		errors++;
	endtask

	task automatic report_cfg(input logic [31:0] got, input logic [31:0] want);
		$display("mismatch reduction_length: got %0d, want %0d", got, want);
		errors++;
	endtask

	// Computes the grid run and queues the emitted entries.
	function automatic void grid_run();
		logic [15:0] hp [ROWS][COLS];
		logic [15:0] vp [ROWS][COLS];
		logic [15:0] a, b;
		int k;
		out_item_t e;
		hp = '{default: '0};
		vp = '{default: '0};
		for (int t = 0; t < int'(red_len) + ROWS + COLS - 2; t++)
			for (int i = ROWS - 1; i >= 0; i--)
				for (int j = COLS - 1; j >= 0; j--) begin
					if (j == 0) begin
						k = t - i;
						a = (k < 0 || k >= int'(red_len)) ? 16'd0 : a_mem[i][k];
					end else
						a = hp[i][j-1];
					if (i == 0) begin
						k = t - j;
						b = (k < 0 || k >= int'(red_len)) ? 16'd0 : b_mem[k][j];
					end else
						b = vp[i-1][j];
					c_acc[i][j] = c_acc[i][j] + 48'($signed(a) * $signed(b));
					hp[i][j] = a;
					vp[i][j] = b;
				end
		for (int i = 0; i < ROWS; i++)
			for (int j = 0; j < COLS; j++) begin
				e.result_row = 3'(i);
				e.result_col = 3'(j);
				e.result_value = c_acc[i][j];
				e.last = (i == ROWS - 1 && j == COLS - 1);
				pending_entries.push_back(e);
			end
	endfunction

	function automatic void apply_item(input in_item_t it);
		case (cmd_t'(it.cmd))
			CMD_LOAD_A: if (it.row < ROWS) begin
				a_mem[it.row][it.column] = it.data_value;
				a_known[it.row][it.column] = 1'b1;
			end
			CMD_LOAD_B: if (it.column < COLS) begin
				b_mem[it.row][it.column] = it.data_value;
				b_known[it.row][it.column] = 1'b1;
			end
			CMD_LOAD_C: if (it.row < ROWS && it.column < COLS)
				c_acc[it.row][it.column] = it.init_value;
			CMD_RUN: grid_run();
			default: ;
		endcase
	endfunction

	// Valid stays high after an accepted item until the next gap, so items
	// with no gap follow back to back.
	task automatic send_item(input in_item_t it);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_item(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_len(input logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		red_len = (v[6:0] > DEPTH) ? DEPTH : v[6:0];
	endtask

	function automatic in_item_t mk(input cmd_t c, input int r, input int col,
			input logic [15:0] d, input logic [47:0] init);
		in_item_t it;
		it.cmd = c;
		it.row = 6'(r);
		it.column = 6'(col);
		it.data_value = d;
		it.init_value = init;
		return it;
	endfunction

	// Fills every operand used by the current length so no unwritten entry is read.
	task automatic fill_operands(input bit extremes);
		logic [15:0] v;
		for (int k = 0; k < int'(red_len); k++) begin
			for (int i = 0; i < ROWS; i++) begin
				v = extremes ? (($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff) : 16'($urandom);
				if (!a_known[i][k])
					send_item(mk(CMD_LOAD_A, i, k, v, 48'($urandom)));
			end
			for (int j = 0; j < COLS; j++) begin
				v = extremes ? 16'h8000 : 16'($urandom);
				if (!b_known[k][j])
					send_item(mk(CMD_LOAD_B, k, j, v, 48'($urandom)));
			end
		end
	endtask

	// Receiver: random stalls, and one long hold-off while the next item waits at the input.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			n = $urandom_range(0, 7);
			if (n == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(5, 40)) @(posedge clk);
			end else if (n < 3) begin
				out_stall <= 1'b1;
				@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Checker.
	always @(posedge clk) begin
		out_item_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL systolic_matmul_accumulate");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_entries.size() == 0) begin
				report("unexpected", out_item, '0);
			end else begin
				want = pending_entries.pop_front();
				if (out_item.result_row !== want.result_row ||
						out_item.result_col !== want.result_col ||
						out_item.result_value !== want.result_value ||
						out_item.last !== want.last)
					report("entry", out_item, want);
			end
		end
	end

	in_item_t directed [$];

	initial begin
		a_known = '{default: 1'b0};
		b_known = '{default: 1'b0};
		c_acc = '{default: '0};
		red_len = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero length emits reset C, out-of-grid loads are dropped,
		// and extreme initial values come out of a zero-length run unchanged.
		directed = '{
			mk(CMD_LOAD_A, 8, 0, 16'h1234, '0),
			mk(CMD_LOAD_B, 0, 8, 16'h1234, '0),
			mk(CMD_LOAD_C, 63, 63, 16'h0, 48'h123),
			mk(CMD_LOAD_C, 8, 0, 16'h0, 48'h456),
			mk(CMD_RUN, 0, 0, 16'h0, '0),
			mk(CMD_LOAD_C, 0, 0, 16'h0, 48'h7fff_ffff_ffff),
			mk(CMD_LOAD_C, 7, 7, 16'h0, 48'h8000_0000_0000),
			mk(CMD_LOAD_C, 3, 4, 16'hffff, 48'hffff_ffff_ffff),
			mk(CMD_RUN, 63, 63, 16'hffff, 48'hffff_ffff_ffff)
		};
		foreach (directed[n])
			send_item(directed[n]);
		wait_idle();

		// Length one with extreme operands, pushing C(0,0) past the top.
		write_len(1);
		fill_operands(1'b1);
		send_item(mk(CMD_LOAD_A, 0, 0, 16'h8000, '0));
		send_item(mk(CMD_LOAD_B, 0, 0, 16'h8000, '0));
		send_item(mk(CMD_RUN, 0, 0, '0, '0));
		wait_idle();

		// Writes above the depth clamp to the full depth.
		write_len(127);
		@(posedge clk);
		if (prdata !== 32'd64)
			report_cfg(prdata, 32'd64);

		// Random phases with short lengths, with one long receiver hold-off.
		for (int ph = 0; ph < 6; ph++) begin
			write_len((ph == 0) ? 32'd0 : 32'($urandom_range(1, 3)));
			fill_operands(1'b0);
			for (int n = 0; n < 26; n++) begin
				int sel;
				sel = (ph == 2 && n == 12) ? 9 : $urandom_range(0, 9);
				case (sel)
					0, 1, 2: send_item(mk(CMD_LOAD_A, $urandom_range(0, 9),
						$urandom_range(0, int'(red_len)), 16'($urandom), 48'($urandom)));
					3, 4, 5: send_item(mk(CMD_LOAD_B, $urandom_range(0, int'(red_len)),
						$urandom_range(0, 9), 16'($urandom), 48'($urandom)));
					6, 7: send_item(mk(CMD_LOAD_C, $urandom_range(0, 9),
						$urandom_range(0, 9), 16'($urandom),
						{16'($urandom), 32'($urandom)}));
					default: begin
						if (ph == 2 && n == 12)
							hold_off = 1'b1;
						send_item(mk(CMD_RUN, $urandom_range(0, 63),
							$urandom_range(0, 63), 16'($urandom), 48'($urandom)));
					end
				endcase
			end
			send_item(mk(CMD_RUN, 0, 0, '0, '0));
			wait_idle();
		end

		if (errors == 0)
			$display("PASS systolic_matmul_accumulate");
		else
			$display("FAIL systolic_matmul_accumulate");
		$finish;
	end

endmodule

// ===== systolic_matmul_accumulate.f =====
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_cell.sv
rtl/systolic_matmul_accumulate.sv
verif/systolic_matmul_accumulate_tb.sv
